[rtl/core/rcm_pkg.sv]
// Shared types and constants for the reentry corridor monitor.
// Used by rcm_cfg_regs, rcm_axis_logic and reentry_corridor_monitor_top; no dependencies.
package rcm_pkg;

  localparam int unsigned TimerW = 32;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [1:0] {
    MODE_OTHER    = 2'd0,
    MODE_REENTRY  = 2'd1,
    MODE_SHALLOW  = 2'd2,
    MODE_OVERLOAD = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    TREQ_NONE     = 2'd0,
    TREQ_REENTRY  = 2'd1,
    TREQ_OVERLOAD = 2'd2,
    TREQ_FAULT    = 2'd3
  } treq_e;

  typedef enum logic [2:0] {
    SREQ_NONE        = 3'd0,
    SREQ_REENTRY     = 3'd1,
    SREQ_CONTINGENCY = 3'd2,
    SREQ_ORBIT       = 3'd3,
    SREQ_FAULT       = 3'd4
  } sreq_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HEAT_FLUX_LIMIT      = 3'd0,
    CFG_OVERLOAD_GRACE_MS    = 3'd1,
    CFG_CATASTROPHIC_MS      = 3'd2,
    CFG_SHALLOW_ANGLE_MDEG   = 3'd3,
    CFG_SKIP_SPEED_CMS       = 3'd4,
    CFG_SKIP_GRACE_MS        = 3'd5,
    CFG_RECOVERY_VSPEED_CMS  = 3'd6,
    CFG_CONTINGENCY_FAULT_MS = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic        [31:0] heat_flux_limit;
    logic        [31:0] overload_grace_ms;
    logic        [31:0] catastrophic_ms;
    logic        [16:0] shallow_angle_mdeg;
    logic        [20:0] skip_speed_cms;
    logic        [31:0] skip_grace_ms;
    logic signed [21:0] recovery_vspeed_cms;
    logic        [31:0] contingency_fault_ms;
  } cfg_t;

  typedef struct packed {
    mode_e              flight_mode;
    logic        [31:0] heat_flux;
    logic signed [18:0] path_angle_mdeg;
    logic        [20:0] airspeed_cms;
    logic signed [21:0] vertical_speed_cms;
    logic         [9:0] tick_ms;
  } item_t;

  localparam logic        [31:0] HeatFluxLimitRst      = 32'd1000000;
  localparam logic        [31:0] OverloadGraceRst      = 32'd3000;
  localparam logic        [31:0] CatastrophicRst       = 32'd10000;
  localparam logic        [16:0] ShallowAngleRst       = 17'd1000;
  localparam logic        [20:0] SkipSpeedRst          = 21'd300000;
  localparam logic        [31:0] SkipGraceRst          = 32'd3000;
  localparam logic signed [21:0] RecoveryVspeedRst     = 22'sd0;
  localparam logic        [31:0] ContingencyFaultRst   = 32'd10000;

  // Saturating millisecond accumulate.
  function automatic logic [TimerW-1:0] sat_add(input logic [TimerW-1:0] a,
                                                input logic [9:0] b);
    logic [TimerW:0] sum;
    sum = {1'b0, a} + {{(TimerW-9){1'b0}}, b};
    return sum[TimerW] ? {TimerW{1'b1}} : sum[TimerW-1:0];
  endfunction

endpackage

[rtl/core/reentry_corridor_monitor_top.sv]
// Top level of the reentry corridor monitor: input register, axis logic, result register.
// Depends on rcm_pkg, rcm_cfg_regs and rcm_axis_logic.
//
// The monitor takes one physics tick per word on the input channel and returns exactly one
// result word per tick, carrying a thermal request and a shallow-corridor request. A word
// lands in an input register, is evaluated by the axis logic (which also updates the thermal,
// shallow and contingency timers) while it waits there, and is captured in the result register
// at the edge on which it moves on, from where it is offered to the consumer. The
// block sustains one word per cycle: the input register refills in the same cycle that its
// word moves on, and it only stalls the input when it is full and the result register is
// held by a stalled consumer. The timers advance strictly in acceptance order, so each tick
// sees the timers left by the previous one. Configuration registers are written through a
// simple write-enable port and should only be changed while no tick is in flight; writes to
// unused indices cannot occur as all eight indices are defined.
module reentry_corridor_monitor_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          cfg_we_i,
  input  logic [rcm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rcm_pkg::CfgDataW-1:0]  cfg_wdata_i,

  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    flight_mode_i,
  input  logic [31:0]                   heat_flux_i,
  input  logic signed [18:0]            path_angle_mdeg_i,
  input  logic [20:0]                   airspeed_cms_i,
  input  logic signed [21:0]            vertical_speed_cms_i,
  input  logic [9:0]                    tick_ms_i,

  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    thermal_request_o,
  output logic [2:0]                    shallow_request_o
);
  import rcm_pkg::*;

  cfg_t   cfg;
  item_t  item_q;
  logic   in_vld_q;
  logic   out_vld_q;
  treq_e  treq, treq_q;
  sreq_e  sreq, sreq_q;
  logic   advance;
  logic   in_take;

  // The word in the input register moves on whenever the result register is free or is
  // being emptied in this cycle.
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  rcm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  rcm_axis_logic u_axis (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (item_q),
    .cfg_i  (cfg),
    .treq_o (treq),
    .sreq_o (sreq)
  );

  // Input register: valid bit under reset, payload loaded on acceptance only.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.flight_mode        <= mode_e'(flight_mode_i);
      item_q.heat_flux          <= heat_flux_i;
      item_q.path_angle_mdeg    <= path_angle_mdeg_i;
      item_q.airspeed_cms       <= airspeed_cms_i;
      item_q.vertical_speed_cms <= vertical_speed_cms_i;
      item_q.tick_ms            <= tick_ms_i;
    end
  end

  // Result register: holds its word until the consumer takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      treq_q <= treq;
      sreq_q <= sreq;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign thermal_request_o = treq_q;
  assign shallow_request_o = sreq_q;

`ifndef NO_ASSERTIONS
  // An accepted word always occupies the input register in the next cycle.
  a_take_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> in_vld_q)
    else $error("accepted word did not reach the input register");

  // The input is only held off while a result is blocked downstream.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_vld_q && out_stall_i && in_vld_q))
    else $error("input stalled without a blocked result");

  // Every word that leaves the input register produces a result.
  a_advance_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_vld_q)
    else $error("evaluated word lost before the result register");

  // A tick outside the reentry modes never requests anything.
  a_other_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && item_q.flight_mode == MODE_OTHER)
      |=> (treq_q == TREQ_NONE && sreq_q == SREQ_NONE))
    else $error("request raised outside the reentry modes");
`endif

endmodule

[rtl/core/rcm_cfg_regs.sv]
// Configuration register file of the reentry corridor monitor.
// Depends on rcm_pkg for the register index codes, the cfg_t struct and reset values.
module rcm_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rcm_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [rcm_pkg::CfgDataW-1:0]   cfg_wdata_i,
  output rcm_pkg::cfg_t                  cfg_o
);
  import rcm_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_HEAT_FLUX_LIMIT:      cfg_d.heat_flux_limit      = cfg_wdata_i;
        CFG_OVERLOAD_GRACE_MS:    cfg_d.overload_grace_ms    = cfg_wdata_i;
        CFG_CATASTROPHIC_MS:      cfg_d.catastrophic_ms      = cfg_wdata_i;
        CFG_SHALLOW_ANGLE_MDEG:   cfg_d.shallow_angle_mdeg   = cfg_wdata_i[16:0];
        CFG_SKIP_SPEED_CMS:       cfg_d.skip_speed_cms       = cfg_wdata_i[20:0];
        CFG_SKIP_GRACE_MS:        cfg_d.skip_grace_ms        = cfg_wdata_i;
        CFG_RECOVERY_VSPEED_CMS:  cfg_d.recovery_vspeed_cms  = $signed(cfg_wdata_i[21:0]);
        CFG_CONTINGENCY_FAULT_MS: cfg_d.contingency_fault_ms = cfg_wdata_i;
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.heat_flux_limit      <= HeatFluxLimitRst;
      cfg_q.overload_grace_ms    <= OverloadGraceRst;
      cfg_q.catastrophic_ms      <= CatastrophicRst;
      cfg_q.shallow_angle_mdeg   <= ShallowAngleRst;
      cfg_q.skip_speed_cms       <= SkipSpeedRst;
      cfg_q.skip_grace_ms        <= SkipGraceRst;
      cfg_q.recovery_vspeed_cms  <= RecoveryVspeedRst;
      cfg_q.contingency_fault_ms <= ContingencyFaultRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/core/rcm_axis_logic.sv]
// Thermal and shallow axis evaluation with the three saturating timers.
// Depends on rcm_pkg for the item and configuration structs and the request codes.
module rcm_axis_logic (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  rcm_pkg::item_t               item_i,
  input  rcm_pkg::cfg_t                cfg_i,
  output rcm_pkg::treq_e               treq_o,
  output rcm_pkg::sreq_e               sreq_o
);
  import rcm_pkg::*;

  logic [TimerW-1:0] thermal_q, thermal_d;
  logic [TimerW-1:0] shallow_q, shallow_d;
  logic [TimerW-1:0] cont_q, cont_d;

  logic        over_limit;
  logic        flat;
  logic        bounce;
  logic [TimerW-1:0] cont_sum;

  // The signed angle is compared against the unsigned threshold on a common 20-bit scale.
  assign over_limit = item_i.heat_flux > cfg_i.heat_flux_limit;
  assign flat = ($signed({item_i.path_angle_mdeg[18], item_i.path_angle_mdeg})
                 < $signed({3'b000, cfg_i.shallow_angle_mdeg}))
                && (item_i.airspeed_cms > cfg_i.skip_speed_cms);
  assign bounce = item_i.vertical_speed_cms > cfg_i.recovery_vspeed_cms;
  assign cont_sum = sat_add(cont_q, item_i.tick_ms);

  always_comb begin
    thermal_d = thermal_q;
    shallow_d = shallow_q;
    cont_d    = cont_q;
    treq_o    = TREQ_NONE;
    sreq_o    = SREQ_NONE;

    if (item_i.flight_mode == MODE_OTHER) begin
      thermal_d = '0;
      shallow_d = '0;
      cont_d    = '0;
    end else begin
      if (item_i.flight_mode != MODE_SHALLOW) begin
        if (over_limit) begin
          thermal_d = sat_add(thermal_q, item_i.tick_ms);
        end else begin
          thermal_d = '0;
          if (item_i.flight_mode == MODE_OVERLOAD) begin
            treq_o = TREQ_REENTRY;
          end
        end
        if (item_i.flight_mode == MODE_REENTRY && thermal_d > cfg_i.overload_grace_ms) begin
          treq_o = TREQ_OVERLOAD;
        end else if (item_i.flight_mode == MODE_OVERLOAD
                     && thermal_d > cfg_i.catastrophic_ms) begin
          treq_o = TREQ_FAULT;
        end
      end

      if (item_i.flight_mode != MODE_OVERLOAD) begin
        shallow_d = flat ? sat_add(shallow_q, item_i.tick_ms) : '0;
        if (item_i.flight_mode == MODE_REENTRY && shallow_d > cfg_i.skip_grace_ms) begin
          sreq_o = SREQ_CONTINGENCY;
        end else if (item_i.flight_mode == MODE_SHALLOW) begin
          cont_d = cont_sum;
          if (bounce) begin
            sreq_o = SREQ_ORBIT;
            cont_d = '0;
          end else if (!flat) begin
            sreq_o = SREQ_REENTRY;
            cont_d = '0;
          end else if (cont_sum > cfg_i.contingency_fault_ms) begin
            sreq_o = SREQ_FAULT;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thermal_q <= '0;
      shallow_q <= '0;
      cont_q    <= '0;
    end else if (step_i) begin
      thermal_q <= thermal_d;
      shallow_q <= shallow_d;
      cont_q    <= cont_d;
    end
  end

endmodule
